FILE: rtl/mctw_pkg.sv
package mctw_pkg;

   // sizing of the channel table and of the tick timebase
   localparam int CHANNELS      = 8;
   localparam int TICKS_PER_SEC = 1000;

   // request / response field widths
   localparam int OP_W   = 3;
   localparam int CHAN_W = 4;
   localparam int MS_W   = 16;
   localparam int CNT_W  = 16;

   // opcodes
   localparam logic [OP_W-1:0] OP_START   = 3'd0;
   localparam logic [OP_W-1:0] OP_FEED    = 3'd1;
   localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
   localparam logic [OP_W-1:0] OP_RUN     = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   // channel modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_SUSP = 2'd2;

   // ms to ticks: TICKS_PER_SEC * (ms + MS_ROUND) / MS_DEN
   localparam int MS_ROUND = 500 / TICKS_PER_SEC;
   localparam int MS_DEN   = 1000;
   localparam int SUM_W    = MS_W + 1;
   localparam int TPS_W    = $clog2(TICKS_PER_SEC + 1);
   localparam int PROD_W   = TPS_W + SUM_W;

   // divide by MS_DEN as a multiply by the rounded-up reciprocal and a
   // shift; exact for every product below 2**PROD_W
   localparam int     DIV_SH  = PROD_W + $clog2(MS_DEN);
   localparam longint RECIP   = ((longint'(1) << DIV_SH) + MS_DEN - 1) / MS_DEN;
   localparam int     RECIP_W = $clog2(RECIP + 1);
   localparam int     WIDE_W  = PROD_W + RECIP_W;

   // command broadcast to the channel cells
   typedef struct packed {
      logic             start;
      logic             feed;
      logic             suspend;
      logic             run;
      logic [CNT_W-1:0] ticks;
   } cell_cmd_type;

   // status returned by each cell
   typedef struct packed {
      logic scan_out;
      logic expire;
      logic idle;
   } cell_stat_type;

endpackage

FILE: rtl/mctw_if.sv
interface mctw_req_if
   import mctw_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CHAN_W-1:0] channel;
   logic [MS_W-1:0]   timeout_ms;

   modport source (output valid, output op, output channel, output timeout_ms, input ready);
   modport sink (input valid, input op, input channel, input timeout_ms, output ready);
endinterface

interface mctw_rsp_if;
   logic valid;
   logic ready;
   logic start_ok;
   logic hw_feed;
   logic tripped;

   modport source (output valid, output start_ok, output hw_feed, output tripped, input ready);
   modport sink (input valid, input start_ok, input hw_feed, input tripped, output ready);
endinterface

FILE: rtl/multi_channel_task_watchdog.sv
// Per-task watchdog table: one cell per channel in a chain. Feed, suspend,
// run, a refused start, a channel number out of range and a tick while
// tripped are answered straight from the idle state. An accepted start
// passes through the two-stage multiply that turns milliseconds into ticks
// (scale, then a reciprocal multiply for the divide). On a tick a scan
// token walks the cell chain one channel per cycle and stops early at the
// first channel that expires. One request is in work at a time; the
// response register is freed by the same edge that accepts the next
// request.
module multi_channel_task_watchdog
   import mctw_pkg::*;
(
   input logic clock,
   input logic reset,
   mctw_req_if.sink   req_bus,
   mctw_rsp_if.source rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                stop_ff, stop_in;
   logic [CHANNELS-1:0] sel_ff, sel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                start_ok_ff, start_ok_in;
   logic                hw_feed_ff, hw_feed_in;
   logic                tripped_ff, tripped_in;

   logic                accept;
   logic                conv_go;
   logic                conv_done;
   logic [CNT_W-1:0]    conv_ticks;
   logic                rsp_load;
   logic                scan_launch;
   cell_cmd_type        cmd;
   logic [CHANNELS-1:0] sel_now;
   logic [CHANNELS-1:0] sel_cell;
   logic [CHANNELS-1:0] idle_vec;
   logic [CHANNELS-1:0] expire_vec;
   logic [CHANNELS:0]   scan_chain;
   cell_stat_type       stat [CHANNELS];

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   // channel decode; numbers beyond the table select nothing
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         sel_now[k] = req_bus.channel == CHAN_W'(k);
      end
   end

   assign sel_cell = (state_ff == S_IDLE) ? sel_now : sel_ff;

   // command broadcast to the cells
   always_comb begin
      cmd.start   = conv_done;
      cmd.feed    = accept && req_bus.op == OP_FEED;
      cmd.suspend = accept && req_bus.op == OP_SUSPEND;
      cmd.run     = accept && req_bus.op == OP_RUN;
      cmd.ticks   = conv_ticks;
   end

   assign scan_launch   = accept && req_bus.op == OP_TICK && !stop_ff;
   assign scan_chain[0] = scan_launch;

   mctw_conv u_conv (
      .clock (clock),
      .reset (reset),
      .go    (conv_go),
      .ms    (req_bus.timeout_ms),
      .done  (conv_done),
      .ticks (conv_ticks)
   );

   // the chain of channel cells
   for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
      mctw_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .sel     (sel_cell[k]),
         .scan_in (scan_chain[k]),
         .stat    (stat[k])
      );
      assign scan_chain[k+1] = stat[k].scan_out;
      assign idle_vec[k]     = stat[k].idle;
      assign expire_vec[k]   = stat[k].expire;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      stop_in     = stop_ff;
      sel_in      = sel_ff;
      conv_go     = 1'b0;
      rsp_load    = 1'b0;
      start_ok_in = 1'b0;
      hw_feed_in  = 1'b0;
      tripped_in  = stop_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sel_in = sel_now;
               unique case (req_bus.op)
                  OP_START: begin
                     if (|(sel_now & idle_vec)) begin
                        conv_go  = 1'b1;
                        state_in = S_CONV;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (!stop_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         S_CONV: begin
            if (conv_done) begin
               rsp_load    = 1'b1;
               start_ok_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            if (|expire_vec) begin
               stop_in    = 1'b1;
               tripped_in = 1'b1;
               rsp_load   = 1'b1;
               state_in   = S_IDLE;
            end else if (scan_chain[CHANNELS]) begin
               hw_feed_in = 1'b1;
               rsp_load   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff <= sel_in;
      if (rsp_load) begin
         start_ok_ff <= start_ok_in;
         hw_feed_ff  <= hw_feed_in;
         tripped_ff  <= tripped_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.start_ok = start_ok_ff;
   assign rsp_bus.hw_feed  = hw_feed_ff;
   assign rsp_bus.tripped  = tripped_ff;

   // checks
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("trip flag cleared");

   a_one_expire: assert property (@(posedge clock) disable iff (reset)
      $onehot0(expire_vec))
      else $error("more than one channel expired in a scan");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a request is in work");

   a_feed_not_tripped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hw_feed_ff) |-> (!tripped_ff && !stop_ff))
      else $error("hardware feed reported while tripped");

endmodule

FILE: rtl/mctw_conv.sv
module mctw_conv
   import mctw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [MS_W-1:0]  ms,
   output logic             done,
   output logic [CNT_W-1:0] ticks
);

   localparam logic [TPS_W-1:0]   TPS_K   = TPS_W'(TICKS_PER_SEC);
   localparam logic [SUM_W-1:0]   ROUND_K = SUM_W'(MS_ROUND);
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

   logic              prod_vld_ff, prod_vld_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  ticks_ff, ticks_in;

   logic [SUM_W-1:0]  ms_sum;
   logic [WIDE_W-1:0] prod_wide;
   logic [WIDE_W-1:0] quot;

   // stage one scales ms, stage two divides by the ms constant through a
   // multiply by its reciprocal and a shift
   always_comb begin
      ms_sum      = SUM_W'(ms) + ROUND_K;
      prod_in     = PROD_W'(TPS_K) * PROD_W'(ms_sum);
      prod_wide   = WIDE_W'(prod_ff) * WIDE_W'(RECIP_K);
      quot        = prod_wide >> DIV_SH;
      ticks_in    = quot[CNT_W-1:0];
      prod_vld_in = go;
      done_in     = prod_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         done_ff     <= done_in;
      end
      prod_ff  <= prod_in;
      ticks_ff <= ticks_in;
   end

   assign done  = done_ff;
   assign ticks = ticks_ff;

endmodule

FILE: rtl/mctw_cell.sv
module mctw_cell
   import mctw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          sel,
   input  logic          scan_in,
   output cell_stat_type stat
);

   logic [1:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] reload_ff, reload_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0] fcnt_ff, fcnt_in;
   logic [CNT_W-1:0] fseen_ff, fseen_in;
   logic             scan_out_ff, scan_out_in;
   logic             expire_ff, expire_in;

   logic [CNT_W-1:0] fcnt_inc;
   logic [CNT_W-1:0] remain_dec;

   // per-channel command handling and the scan token pass
   always_comb begin
      fcnt_inc    = fcnt_ff + 1'b1;
      remain_dec  = remain_ff - 1'b1;
      mode_in     = mode_ff;
      reload_in   = reload_ff;
      remain_in   = remain_ff;
      fcnt_in     = fcnt_ff;
      fseen_in    = fseen_ff;
      expire_in   = 1'b0;
      if (sel) begin
         if (cmd.start) begin
            reload_in = cmd.ticks;
            remain_in = cmd.ticks;
            mode_in   = MODE_RUN;
         end
         if (cmd.feed) begin
            // never land on the value the last check saw
            fcnt_in = (fcnt_inc == fseen_ff) ? fcnt_inc + 1'b1 : fcnt_inc;
         end
         if (cmd.suspend) begin
            mode_in = MODE_SUSP;
         end
         if (cmd.run) begin
            mode_in = MODE_RUN;
         end
      end
      if (scan_in && mode_ff == MODE_RUN) begin
         if (fcnt_ff != fseen_ff) begin
            fseen_in  = fcnt_ff;
            remain_in = reload_ff;
         end else begin
            remain_in = remain_dec;
            expire_in = remain_dec == '0;
         end
      end
      scan_out_in = scan_in && !expire_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         reload_ff   <= '0;
         remain_ff   <= '0;
         fcnt_ff     <= '0;
         fseen_ff    <= '0;
         scan_out_ff <= 1'b0;
         expire_ff   <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         reload_ff   <= reload_in;
         remain_ff   <= remain_in;
         fcnt_ff     <= fcnt_in;
         fseen_ff    <= fseen_in;
         scan_out_ff <= scan_out_in;
         expire_ff   <= expire_in;
      end
   end

   assign stat.scan_out = scan_out_ff;
   assign stat.expire   = expire_ff;
   assign stat.idle     = mode_ff == MODE_IDLE;

endmodule
